FILE: rtl/clpe_pkg.sv
// Package with command and status codes for the circular list position engine.
package clpe_pkg;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_INS_POS   = 3'd2,
		CMD_DEL_FRONT = 3'd3,
		CMD_DEL_BACK  = 3'd4,
		CMD_DEL_POS   = 3'd5,
		CMD_DUMP      = 3'd6,
		CMD_NOP       = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_WALK,
		FSM_LINK,
		FSM_DUMP,
		FSM_WRITE,
		FSM_RESULT
	} fsm_t;

	localparam int CMD_W    = 3;
	localparam int IN_VAL_W = 32;
	localparam int POS_W    = 8;
	localparam int OUT_VAL_W = 32;
	localparam int COUNT_W  = 5;

endpackage

FILE: rtl/clpe_if.sv
// Valid/ready channel interfaces for command and result transactions.
interface clpe_cmd_if;
	import clpe_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic signed [IN_VAL_W-1:0] value;
	logic [POS_W-1:0]    position;
	modport source (output valid, command, value, position, input ready);
	modport sink   (input valid, command, value, position, output ready);
endinterface

interface clpe_res_if;
	import clpe_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic signed [OUT_VAL_W-1:0] element_value;
	logic                 element_valid;
	logic [COUNT_W-1:0]   element_count;
	logic                 last_result;
	modport source (output valid, status, element_value, element_valid, element_count,
		last_result, input ready);
	modport sink   (input valid, status, element_value, element_valid, element_count,
		last_result, output ready);
endinterface

FILE: rtl/circular_list_position_engine_core.sv
// Circular singly linked list engine held in a slot store with per-slot links.
//
//   channel  direction  transaction
//   cmd      in         command, value, position
//   res      out        status, element_value, element_valid, element_count, last_result
//
// One command is worked at a time. Front inserts and front deletes pass through the
// walk, link, write and result states after acceptance. A command that needs the
// element before position p walks the links from the head, reading each link and then
// following it, as back and positional commands do. Rejected commands, unused
// commands and an empty dump go straight to the result state. A dump reads each
// element and then emits it as a result, holding while the sink is not free.
// Reset clears the slot map, head, tail and count; the memories need no clear.
// A result stalled at the sink holds the engine; the next command can be taken in
// the cycle after the final result of the current one has been delivered.
module circular_list_position_engine_core #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	clpe_cmd_if.sink    cmd,
	clpe_res_if.source  res
);
	import clpe_pkg::*;

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// Slot memories.
	logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
	logic [SW-1:0]          link_mem [CAPACITY];

	fsm_t state_q, state_d;
	logic [CAPACITY-1:0] free_q;
	logic [SW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	logic [2:0]             cmd_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW:0]            pos_q;
	logic [CW:0]            step_q;   // current position of cur_q
	logic [SW-1:0]          cur_q;    // slot being visited
	logic [SW-1:0]          new_q;    // slot taken by an insert
	logic [SW-1:0]          pred_q;   // predecessor kept across the successor read
	logic [SW-1:0]          tgt_q;    // slot removed by a delete
	logic [SW-1:0]          link_mem_succ;
	logic [1:0]             st_q;
	logic                   rd_pend_q;

	// Result register.
	logic                   rv_q;
	logic [1:0]             rs_q;
	logic [OUT_VAL_W-1:0]   re_q;
	logic                   rev_q, rl_q;
	logic [CW-1:0]          rc_q;

	// Read ports with registered data.
	logic [SW-1:0]          rd_addr;
	logic [SW-1:0]          link_rd_s1;
	logic [VALUE_WIDTH-1:0] val_rd_s1;

	// Lowest free slot.
	logic [SW-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_slot = SW'(i);
			end
		end
	end

	// Decode of the incoming command: effective position and status.
	logic [CW:0] in_pos;
	logic [1:0]  in_st;
	logic        is_ins, is_del;
	always_comb begin
		is_ins = cmd.command == CMD_INS_FRONT || cmd.command == CMD_INS_BACK ||
			cmd.command == CMD_INS_POS;
		is_del = cmd.command == CMD_DEL_FRONT || cmd.command == CMD_DEL_BACK ||
			cmd.command == CMD_DEL_POS;
		case (cmd.command)
			CMD_INS_FRONT, CMD_DEL_FRONT: in_pos = (CW+1)'(1);
			CMD_INS_BACK:                 in_pos = (CW+1)'(count_q) + 1'b1;
			CMD_DEL_BACK:                 in_pos = (CW+1)'(count_q);
			default: begin
				if (cmd.position > 8'((1 << (CW + 1)) - 1)) begin
					in_pos = '1;
				end else begin
					in_pos = (CW+1)'(cmd.position);
				end
			end
		endcase
		in_st = ST_OK;
		if (is_ins) begin
			if (in_pos == '0 || in_pos > (CW+1)'(count_q) + 1'b1) begin
				in_st = ST_RANGE;
			end else if (count_q >= CW'(CAPACITY)) begin
				in_st = ST_FULL;
			end
		end else if (is_del) begin
			if (count_q == '0) begin
				in_st = ST_EMPTY;
			end else if (in_pos == '0 || in_pos > (CW+1)'(count_q)) begin
				in_st = ST_RANGE;
			end
		end
	end

	wire accept   = cmd.valid && cmd.ready;
	wire res_free = !rv_q || res.ready;

	// A new result is loaded when a dump element or a single result is ready.
	wire rv_set = res_free && ((state_q == FSM_DUMP && !rd_pend_q) || state_q == FSM_RESULT);

	// The walk stops once cur_q holds the element before the target position.
	wire walk_done = pos_q <= (CW+1)'(1) || step_q >= pos_q - 1'b1;

	assign cmd.ready = (state_q == FSM_IDLE) && !rv_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					if (cmd.command == CMD_DUMP && count_q != '0) begin
						state_d = FSM_DUMP;
					end else if (in_st != ST_OK || (!is_ins && !is_del)) begin
						state_d = FSM_RESULT;
					end else begin
						state_d = FSM_WALK;
					end
				end
			end
			FSM_WALK: begin
				if (rd_pend_q) begin
					state_d = FSM_WALK;
				end else if (walk_done) begin
					state_d = FSM_LINK;
				end
			end
			FSM_LINK:   state_d = rd_pend_q ? FSM_LINK : FSM_WRITE;
			FSM_WRITE:  state_d = FSM_RESULT;
			FSM_RESULT: if (res_free) state_d = FSM_IDLE;
			FSM_DUMP: begin
				if (!rd_pend_q && res_free && step_q >= (CW+1)'(count_q)) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// Read address of the memories.
	assign rd_addr = cur_q;

	always_ff @(posedge clk) begin
		link_rd_s1 <= link_mem[rd_addr];
		val_rd_s1  <= val_mem[rd_addr];
	end

	// Decode of the registered command: insert, front position and back insert.
	wire is_ins_q = cmd_q == CMD_INS_FRONT || cmd_q == CMD_INS_BACK || cmd_q == CMD_INS_POS;
	wire front_q  = pos_q == (CW+1)'(1);
	wire back_ins = is_ins_q && pos_q == (CW+1)'(count_q) + 1'b1;

	// Successor of the deleted node, read in the link state.
	assign link_mem_succ = link_rd_s1;

	// Memory writes happen in the link and write states.
	always_ff @(posedge clk) begin
		if (state_q == FSM_WRITE) begin
			if (is_ins_q) begin
				val_mem[new_q] <= val_q;
				if (count_q == '0) begin
					link_mem[new_q] <= new_q;
				end else if (front_q) begin
					link_mem[new_q] <= head_q;
				end else if (back_ins) begin
					link_mem[new_q] <= head_q;
				end else begin
					link_mem[new_q] <= link_rd_s1;
				end
			end
		end else if (state_q == FSM_LINK && !rd_pend_q) begin
			// Predecessor link updates; its old successor is in link_rd_s1.
			if (is_ins_q) begin
				if (count_q != '0) begin
					if (front_q) begin
						link_mem[tail_q] <= new_q;
					end else if (!back_ins) begin
						link_mem[cur_q] <= new_q;
					end else begin
						link_mem[tail_q] <= new_q;
					end
				end
			end else if (count_q != CW'(1)) begin
				if (front_q) begin
					link_mem[tail_q] <= link_rd_s1;
				end else begin
					link_mem[cur_q] <= link_mem_succ;
				end
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			free_q    <= '1;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			rv_q      <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q    <= rv_set || (rv_q && !res.ready);
			unique case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						rd_pend_q <= 1'b1;
					end
				end
				FSM_WALK: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (!walk_done) begin
						rd_pend_q <= 1'b1;
					end else if (!is_ins_q && !front_q && count_q != CW'(1)) begin
						rd_pend_q <= 1'b1;
					end
				end
				FSM_LINK: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (!is_ins_q) begin
						count_q <= count_q - 1'b1;
						if (count_q == CW'(1) || front_q) begin
							free_q[head_q] <= 1'b1;
							if (count_q != CW'(1)) begin
								head_q <= link_rd_s1;
							end
						end else begin
							free_q[tgt_q] <= 1'b1;
							if (tgt_q == tail_q) begin
								tail_q <= cur_q;
							end
						end
					end
				end
				FSM_WRITE: begin
					// Insert bookkeeping follows the memory writes that use the old head.
					if (is_ins_q) begin
						free_q[new_q] <= 1'b0;
						count_q <= count_q + 1'b1;
						if (count_q == '0) begin
							head_q <= new_q;
							tail_q <= new_q;
						end else if (front_q) begin
							head_q <= new_q;
						end else if (back_ins) begin
							tail_q <= new_q;
						end
					end
				end
				FSM_DUMP: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (res_free) begin
						if (step_q < (CW+1)'(count_q)) begin
							rd_pend_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the walk and the result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			FSM_IDLE: begin
				cmd_q  <= cmd.command;
				val_q  <= VALUE_WIDTH'(cmd.value);
				pos_q  <= in_pos;
				st_q   <= in_st;
				new_q  <= free_slot;
				cur_q  <= head_q;
				step_q <= (CW+1)'(1);
			end
			FSM_WALK: begin
				if (!rd_pend_q) begin
					if (!walk_done) begin
						cur_q  <= link_rd_s1;
						step_q <= step_q + 1'b1;
					end else if (!is_ins_q && !front_q && count_q != CW'(1)) begin
						// Read the successor of the target.
						tgt_q <= link_rd_s1;
						cur_q <= link_rd_s1;
					end
				end
			end
			FSM_LINK: begin
				if (rd_pend_q && !is_ins_q && !front_q && count_q != CW'(1)) begin
					cur_q <= pred_q;
				end
			end
			FSM_DUMP: begin
				if (!rd_pend_q && res_free) begin
					cur_q  <= link_rd_s1;
					step_q <= step_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Predecessor kept across the successor read.
	always_ff @(posedge clk) begin
		if (state_q == FSM_WALK && !rd_pend_q) begin
			pred_q <= cur_q;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == FSM_DUMP && !rd_pend_q && res_free) begin
			rs_q  <= ST_OK;
			re_q  <= OUT_VAL_W'(val_rd_s1);
			rev_q <= 1'b1;
			rl_q  <= step_q >= (CW+1)'(count_q);
			rc_q  <= count_q;
		end else if (state_q == FSM_RESULT && res_free) begin
			rs_q  <= st_q;
			re_q  <= '0;
			rev_q <= 1'b0;
			rl_q  <= 1'b1;
			rc_q  <= count_q;
		end
	end

	assign res.valid         = rv_q;
	assign res.status        = rs_q;
	assign res.element_value = re_q;
	assign res.element_valid = rev_q;
	assign res.element_count = COUNT_W'(rc_q);
	assign res.last_result   = rl_q;

endmodule
